// File: sv/lug_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lug_pkg
// Shared constants, types and codes of the Lehmer uniform generator.
// ----------------------------------------------------------------------------
package lug_pkg;

    localparam int STATE_BITS    = 31;
    localparam int FRACTION_BITS = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int BOUND_W  = 16;
    localparam int MAG_W    = 16;
    localparam int RAW_W    = 31;
    localparam int SCALED_W = 32;
    localparam int WHOLE_W  = 17;

    // derived widths
    localparam int MOD_W  = STATE_BITS + 1;
    localparam int K_W    = MAG_W + FRACTION_BITS;
    localparam int OPB_W  = (STATE_BITS > K_W) ? STATE_BITS : K_W;
    localparam int IDX_W  = $clog2(OPB_W);
    localparam int VAL_W  = ((K_W + 2) > (SCALED_W + 1)) ? (K_W + 2) : (SCALED_W + 1);
    localparam int PICK_W = MAG_W + 2;

    // configuration port
    localparam int CFG_DATA_W = (STATE_BITS > 32) ? 64 : 32;
    localparam int STRIDE_LOG = (STATE_BITS > 32) ? 3 : 2;
    localparam int REG_IDX_W  = 2;
    localparam int PADDR_W    = STRIDE_LOG + REG_IDX_W;

    localparam logic [REG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODULUS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SEED       = 2'd2;

    localparam logic [STATE_BITS-1:0] MULT_RESET = STATE_BITS'(64'd16807);
    localparam logic [STATE_BITS-1:0] MOD_RESET  = STATE_BITS'(64'd2147483647);
    localparam logic [STATE_BITS-1:0] SEED_RESET = STATE_BITS'(64'd100);

    // operation codes
    localparam logic [OP_W-1:0] OP_RESEED  = 2'd0;
    localparam logic [OP_W-1:0] OP_UNIFORM = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK    = 2'd2;

    typedef logic [OP_W-1:0]           op_t;
    typedef logic signed [BOUND_W-1:0] bound_t;
    typedef logic [RAW_W-1:0]          raw_t;
    typedef logic signed [SCALED_W-1:0] scaled_t;
    typedef logic signed [WHOLE_W-1:0] whole_t;

    typedef struct packed {
        logic [STATE_BITS-1:0] multiplier;
        logic [STATE_BITS-1:0] modulus;
        logic [STATE_BITS-1:0] seed_value;
    } lug_cfg_t;

    typedef struct packed {
        logic                  start;
        logic [STATE_BITS-1:0] a;
        logic [OPB_W-1:0]      b;
        logic [IDX_W-1:0]      top;
        logic [MOD_W-1:0]      m;
    } lug_cmd_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [STATE_BITS-1:0] rem;
        logic [OPB_W-1:0]      quot;
    } lug_stat_t;

endpackage

// File: sv/lug_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lug_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface lug_in_if;
    import lug_pkg::*;

    logic   valid;
    logic   ready;
    op_t    op;
    bound_t low_bound;
    bound_t high_bound;

    modport source (output valid, output op, output low_bound, output high_bound,
                    input ready);
    modport sink   (input valid, input op, input low_bound, input high_bound,
                    output ready);
endinterface

interface lug_out_if;
    import lug_pkg::*;

    logic    valid;
    logic    ready;
    raw_t    raw_state;
    scaled_t scaled_q16;
    whole_t  whole_value;

    modport source (output valid, output raw_state, output scaled_q16,
                    output whole_value, input ready);
    modport sink   (input valid, input raw_state, input scaled_q16,
                    input whole_value, output ready);
endinterface

// File: sv/lug_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lug_cfg_regs
// APB register file: multiplier, modulus and seed value.
// ----------------------------------------------------------------------------
module lug_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lug_pkg::PADDR_W-1:0]    paddr,
    input  logic [lug_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lug_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output lug_pkg::lug_cfg_t              cfg
);
    import lug_pkg::*;

    logic [STATE_BITS-1:0] mult_reg;
    logic [STATE_BITS-1:0] mod_reg;
    logic [STATE_BITS-1:0] seed_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[PADDR_W-1:STRIDE_LOG];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            mod_reg  <= MOD_RESET;
            seed_reg <= SEED_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MULTIPLIER: mult_reg <= STATE_BITS'(pwdata);
                REG_MODULUS:    mod_reg  <= STATE_BITS'(pwdata);
                REG_SEED:       seed_reg <= STATE_BITS'(pwdata);
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MULTIPLIER: prdata = CFG_DATA_W'(mult_reg);
            REG_MODULUS:    prdata = CFG_DATA_W'(mod_reg);
            REG_SEED:       prdata = CFG_DATA_W'(seed_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.multiplier = mult_reg;
    assign cfg.modulus    = mod_reg;
    assign cfg.seed_value = seed_reg;

endmodule

// File: sv/lug_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lug_muldiv
// Bit-serial multiply with modular remainder and quotient, one bit of b per cycle.
// ----------------------------------------------------------------------------
module lug_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  lug_pkg::lug_cmd_t  cmd,
    output lug_pkg::lug_stat_t stat
);
    import lug_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [STATE_BITS-1:0] r_reg;
    logic [OPB_W-1:0]      q_reg;
    logic [OPB_W-1:0]      b_reg;
    logic [STATE_BITS-1:0] a_reg;
    logic [MOD_W-1:0]      m_reg;

    logic [STATE_BITS+1:0] sum;
    logic [STATE_BITS+1:0] m1;
    logic [STATE_BITS+1:0] m2;
    logic [STATE_BITS+1:0] d1;
    logic [STATE_BITS+1:0] d2;
    logic [STATE_BITS-1:0] r_next;
    logic [1:0]            digit;
    logic [OPB_W-1:0]      q_next;

    // 2r + bit*a stays below 3m: subtract m or 2m
    always_comb
    begin
        sum = {1'b0, r_reg, 1'b0} + (b_reg[idx_reg] ? (STATE_BITS+2)'(a_reg) : '0);
        m1  = (STATE_BITS+2)'(m_reg);
        m2  = {m_reg, 1'b0};
        d1  = sum - m1;
        d2  = sum - m2;
        if (sum >= m2)
        begin
            r_next = STATE_BITS'(d2);
            digit  = 2'd2;
        end
        else if (sum >= m1)
        begin
            r_next = STATE_BITS'(d1);
            digit  = 2'd1;
        end
        else
        begin
            r_next = STATE_BITS'(sum);
            digit  = 2'd0;
        end
        q_next = {q_reg[OPB_W-2:0], 1'b0} + OPB_W'(digit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            r_reg    <= '0;
            q_reg    <= '0;
            b_reg    <= '0;
            a_reg    <= '0;
            m_reg    <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= cmd.top;
            r_reg    <= '0;
            q_reg    <= '0;
            b_reg    <= cmd.b;
            a_reg    <= cmd.a;
            m_reg    <= cmd.m;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
            if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = r_reg;
    assign stat.quot = q_reg;

endmodule

// File: sv/lug_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lug_seq
// Operation sequencer: state word, unit commands, result scaling, output register.
// ----------------------------------------------------------------------------
module lug_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  lug_pkg::lug_cfg_t  cfg,
    lug_in_if.sink             in_ch,
    lug_out_if.source          out_ch,
    output lug_pkg::lug_cmd_t  cmd,
    input  lug_pkg::lug_stat_t stat
);
    import lug_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_MULT,
        ST_SCALE,
        ST_FINISH
    } seq_state_t;

    seq_state_t            state_reg;
    logic [STATE_BITS-1:0] cur_reg;
    op_t                   op_reg;
    bound_t                lo_reg;
    bound_t                hi_reg;
    lug_cmd_t              cmd_reg;
    logic                  out_valid_reg;
    raw_t                  raw_reg;
    scaled_t               scaled_reg;
    whole_t                whole_reg;

    logic [MOD_W-1:0]      m_eff;
    logic signed [BOUND_W:0] diff;
    logic signed [BOUND_W:0] diff_neg;
    logic [MAG_W-1:0]      dmag;
    logic signed [BOUND_W:0] hi_ext;
    logic signed [BOUND_W:0] hi_neg;
    logic [MAG_W-1:0]      hmag;
    logic [OPB_W-1:0]      scale_b;
    logic [IDX_W-1:0]      scale_top;
    logic signed [VAL_W-1:0] lo_shift;
    logic signed [VAL_W-1:0] q_val;
    logic signed [VAL_W-1:0] val;
    logic [VAL_W-SCALED_W:0] val_hi;
    scaled_t               scaled_res;
    logic signed [PICK_W-1:0] base;
    logic signed [PICK_W-1:0] pick;
    logic                  rem_nz;
    logic                  out_free;

    assign m_eff = (cfg.modulus == '0) ? (MOD_W'(1) << STATE_BITS) : MOD_W'(cfg.modulus);

    always_comb
    begin
        diff     = (BOUND_W+1)'(hi_reg) - (BOUND_W+1)'(lo_reg);
        diff_neg = -diff;
        dmag     = diff[BOUND_W] ? MAG_W'(diff_neg) : MAG_W'(diff);
        hi_ext   = (BOUND_W+1)'(hi_reg);
        hi_neg   = -hi_ext;
        hmag     = hi_reg[BOUND_W-1] ? MAG_W'(hi_neg) : MAG_W'(hi_ext);
        if (op_reg == OP_UNIFORM)
        begin
            scale_b   = OPB_W'({dmag, {FRACTION_BITS{1'b0}}});
            scale_top = IDX_W'(K_W - 1);
        end
        else
        begin
            scale_b   = OPB_W'(hmag);
            scale_top = IDX_W'(MAG_W - 1);
        end
    end

    // uniform draw: low*2^F +/- quotient, saturated
    always_comb
    begin
        lo_shift = VAL_W'(lo_reg) <<< FRACTION_BITS;
        q_val    = VAL_W'(stat.quot[K_W-1:0]);
        val      = diff[BOUND_W] ? (lo_shift - q_val) : (lo_shift + q_val);
        val_hi   = val[VAL_W-1:SCALED_W-1];
        if (!val[VAL_W-1] && (|val_hi))
            scaled_res = {1'b0, {(SCALED_W-1){1'b1}}};
        else if (val[VAL_W-1] && !(&val_hi))
            scaled_res = {1'b1, {(SCALED_W-1){1'b0}}};
        else
            scaled_res = SCALED_W'(val);
    end

    // integer pick, truncated toward zero
    always_comb
    begin
        rem_nz = (stat.rem != '0);
        if (!hi_reg[BOUND_W-1])
        begin
            base = PICK_W'(lo_reg) + PICK_W'(stat.quot[MAG_W-1:0]);
            pick = (base[PICK_W-1] && rem_nz) ? base + PICK_W'(1) : base;
        end
        else
        begin
            base = PICK_W'(lo_reg) - PICK_W'(stat.quot[MAG_W-1:0]);
            pick = (!base[PICK_W-1] && (base != '0) && rem_nz) ? base - PICK_W'(1) : base;
        end
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= SEED_RESET;
            op_reg        <= OP_RESEED;
            lo_reg        <= '0;
            hi_reg        <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            raw_reg       <= '0;
            scaled_reg    <= '0;
            whole_reg     <= '0;
        end
        else
        begin
            cmd_reg.start <= (state_reg == ST_CHECK) ||
                             (((state_reg == ST_REDUCE) || (state_reg == ST_MULT)) && stat.done);
            if ((state_reg == ST_FINISH) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg <= in_ch.op;
                        lo_reg <= in_ch.low_bound;
                        hi_reg <= in_ch.high_bound;
                        case (in_ch.op)
                            OP_RESEED:
                            begin
                                cur_reg   <= cfg.seed_value;
                                state_reg <= ST_FINISH;
                            end
                            OP_UNIFORM, OP_PICK: state_reg <= ST_CHECK;
                            default:             state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    cmd_reg.m     <= m_eff;
                    cmd_reg.top   <= IDX_W'(STATE_BITS - 1);
                    if (MOD_W'(cur_reg) >= m_eff)
                    begin
                        // bring the state below the modulus first
                        cmd_reg.a <= STATE_BITS'(1);
                        cmd_reg.b <= OPB_W'(cur_reg);
                        state_reg <= ST_REDUCE;
                    end
                    else
                    begin
                        cmd_reg.a <= cur_reg;
                        cmd_reg.b <= OPB_W'(cfg.multiplier);
                        state_reg <= ST_MULT;
                    end
                end
                ST_REDUCE:
                begin
                    if (stat.done)
                    begin
                        cmd_reg.a     <= stat.rem;
                        cmd_reg.b     <= OPB_W'(cfg.multiplier);
                        cmd_reg.top   <= IDX_W'(STATE_BITS - 1);
                        state_reg     <= ST_MULT;
                    end
                end
                ST_MULT:
                begin
                    if (stat.done)
                    begin
                        cur_reg       <= stat.rem;
                        cmd_reg.a     <= stat.rem;
                        cmd_reg.b     <= scale_b;
                        cmd_reg.top   <= scale_top;
                        state_reg     <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (stat.done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        raw_reg       <= RAW_W'(cur_reg);
                        scaled_reg    <= (op_reg == OP_UNIFORM) ? scaled_res : '0;
                        whole_reg     <= (op_reg == OP_PICK) ? WHOLE_W'(pick) : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.raw_state   = raw_reg;
    assign out_ch.scaled_q16  = scaled_reg;
    assign out_ch.whole_value = whole_reg;
    assign cmd                = cmd_reg;

endmodule

// File: sv/lehmer_uniform_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_uniform_generator
// Park-Miller style multiplicative generator with scaled and integer draws.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A reseed or an unused op code goes from
// acceptance straight to the finishing state. A uniform draw or an integer pick
// runs a state-update pass and then a scaling pass, with a reduction pass first
// when the stored state is not below the modulus. Each pass runs on the single
// remainder/quotient step unit, which consumes one bit of its multiplier operand
// per cycle: STATE_BITS bits for the state update, then 16 + FRACTION_BITS bits
// (uniform) or 16 bits (pick) for the scaling. A finished result waits in the
// output register while the next request is already taken.
module lehmer_uniform_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    lug_in_if.sink                         in_ch,
    lug_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lug_pkg::PADDR_W-1:0]    paddr,
    input  logic [lug_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lug_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lug_pkg::*;

    lug_cfg_t  cfg;
    lug_cmd_t  cmd;
    lug_stat_t stat;

    lug_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lug_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    lug_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

    // no new transaction while the step unit is running
    a_ready_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !stat.busy)
        else $error("request accepted while step unit busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> stat.busy)
        else $error("step unit did not start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(stat.busy))
        else $error("step unit done without running");

endmodule
